/* hw/rtl/erfp_pkg.sv */
// ----------------------------------------------------------------------------
// erfp_pkg
// Shared types and constants for the escaped reply frame parser.
// ----------------------------------------------------------------------------
package erfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    localparam int LEN_W = 9;
    localparam logic [LEN_W-1:0] PAYLOAD_LEN_RESET = 9'd256;

    localparam logic [7:0] ESC_BYTE = 8'hDB;
    localparam logic [7:0] ESC_LF   = 8'hDC;
    localparam logic [7:0] ESC_ESC  = 8'hDD;
    localparam logic [7:0] LF_BYTE  = 8'h0A;
    localparam logic [7:0] CMD_ERR  = 8'h65;
    localparam logic [7:0] CMD_OUT  = 8'h6F;

    localparam int TDATA_W = 24;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_ECODE,
        PH_PAYLOAD,
        PH_CSUM,
        PH_TRAILER
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_DEVICE,
        ST_CSUM,
        ST_CMD,
        ST_ESC
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
        status_t    status;
        logic [7:0] code;
    } result_t;

endpackage

/* hw/rtl/erfp_in_stage.sv */
// ----------------------------------------------------------------------------
// erfp_in_stage
// Input register: holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module erfp_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // rx_byte [7:0]
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_axis_tready = !valid_reg || byte_take;
    assign byte_valid    = valid_reg;
    assign byte_data     = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (byte_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            data_reg <= s_axis_tdata;
        end
    end

endmodule

/* hw/rtl/erfp_decoder.sv */
// ----------------------------------------------------------------------------
// erfp_decoder
// Frame state machine: unstuffs bytes, tracks phase, sum and payload count,
// and forms one result per payload byte or end of frame.
// ----------------------------------------------------------------------------
module erfp_decoder
#(
    parameter int MAX_PAYLOAD = erfp_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [erfp_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                          fire,
    input  logic [7:0]                    rx_byte,
    output logic                          res_valid,
    output erfp_pkg::result_t             res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    erfp_pkg::phase_t                  phase_reg;
    erfp_pkg::phase_t                  phase_next;
    logic                              esc_reg;
    logic                              esc_next;
    logic [7:0]                        sum_reg;
    logic [7:0]                        sum_next;
    logic [CNT_W-1:0]                  left_reg;
    logic [CNT_W-1:0]                  left_next;
    logic                              reply_reg;
    logic                              reply_next;
    logic [7:0]                        code_reg;
    logic [7:0]                        code_next;
    logic [erfp_pkg::LEN_W-1:0]        len_reg;

    logic [7:0]                        sum_acc;
    logic [CNT_W-1:0]                  len_sat;
    logic [CNT_W-1:0]                  left_dec;
    logic [7:0]                        ch;
    logic                              ch_ok;
    logic                              finish;
    erfp_pkg::status_t                 fin_status;
    erfp_pkg::status_t                 end_status;

    assign sum_acc  = (phase_reg != erfp_pkg::PH_TRAILER) ? sum_reg + rx_byte : sum_reg;
    assign len_sat  = (32'(len_reg) > 32'(MAX_PAYLOAD)) ? CNT_W'(MAX_PAYLOAD)
                                                       : CNT_W'(len_reg);
    assign left_dec = (left_reg != '0) ? left_reg - CNT_W'(1) : '0;

    always_comb
    begin
        if (sum_acc != 8'd0)
        begin
            end_status = erfp_pkg::ST_CSUM;
        end
        else if (reply_reg)
        begin
            end_status = erfp_pkg::ST_DEVICE;
        end
        else
        begin
            end_status = erfp_pkg::ST_OK;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        reply_next = reply_reg;
        code_next  = code_reg;
        ch         = rx_byte;
        ch_ok      = 1'b0;
        finish     = 1'b0;
        fin_status = erfp_pkg::ST_OK;
        res_valid  = 1'b0;
        res.data   = 8'd0;
        res.done   = 1'b0;
        res.status = erfp_pkg::ST_OK;
        res.code   = 8'd0;

        if (fire)
        begin
            sum_next = sum_acc;
            if (esc_reg)
            begin
                esc_next = 1'b0;
                case (rx_byte)
                    erfp_pkg::ESC_LF:
                    begin
                        ch    = erfp_pkg::LF_BYTE;
                        ch_ok = 1'b1;
                    end
                    erfp_pkg::ESC_ESC:
                    begin
                        ch    = erfp_pkg::ESC_BYTE;
                        ch_ok = 1'b1;
                    end
                    default:
                    begin
                        finish     = 1'b1;
                        fin_status = erfp_pkg::ST_ESC;
                    end
                endcase
            end
            else if (rx_byte == erfp_pkg::ESC_BYTE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                ch_ok = 1'b1;
            end

            if (ch_ok)
            begin
                unique case (phase_reg)
                    erfp_pkg::PH_ECODE:
                    begin
                        code_next  = ch;
                        phase_next = erfp_pkg::PH_CSUM;
                    end
                    erfp_pkg::PH_PAYLOAD:
                    begin
                        res_valid = 1'b1;
                        res.data  = ch;
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            phase_next = erfp_pkg::PH_CSUM;
                        end
                    end
                    erfp_pkg::PH_CSUM:
                    begin
                        if (ch == erfp_pkg::LF_BYTE)
                        begin
                            finish     = 1'b1;
                            fin_status = end_status;
                        end
                        else
                        begin
                            phase_next = erfp_pkg::PH_TRAILER;
                        end
                    end
                    erfp_pkg::PH_TRAILER:
                    begin
                        finish     = 1'b1;
                        fin_status = end_status;
                    end
                    default:
                    begin
                        if (ch == erfp_pkg::CMD_ERR)
                        begin
                            reply_next = 1'b1;
                            phase_next = erfp_pkg::PH_ECODE;
                        end
                        else if (ch == erfp_pkg::CMD_OUT)
                        begin
                            left_next  = len_sat;
                            phase_next = (len_sat == '0) ? erfp_pkg::PH_CSUM
                                                         : erfp_pkg::PH_PAYLOAD;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            fin_status = erfp_pkg::ST_CMD;
                        end
                    end
                endcase
            end

            // end of frame: report and clear for the next frame
            if (finish)
            begin
                res_valid  = 1'b1;
                res.data   = 8'd0;
                res.done   = 1'b1;
                res.status = fin_status;
                res.code   = (fin_status == erfp_pkg::ST_DEVICE) ? code_reg : 8'd0;
                phase_next = erfp_pkg::PH_CMD;
                esc_next   = 1'b0;
                sum_next   = 8'd0;
                left_next  = '0;
                reply_next = 1'b0;
                code_next  = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= erfp_pkg::PH_CMD;
            esc_reg   <= 1'b0;
            sum_reg   <= 8'd0;
            left_reg  <= '0;
            reply_reg <= 1'b0;
            code_reg  <= 8'd0;
            len_reg   <= erfp_pkg::PAYLOAD_LEN_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            sum_reg   <= sum_next;
            left_reg  <= left_next;
            reply_reg <= reply_next;
            code_reg  <= code_next;
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
        end
    end

endmodule

/* hw/rtl/erfp_out_stage.sv */
// ----------------------------------------------------------------------------
// erfp_out_stage
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module erfp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  erfp_pkg::result_t res,
    output logic              can_load,
    output logic              out_valid,
    output erfp_pkg::result_t out_res,
    input  logic              out_ready
);

    logic              valid_reg;
    logic              valid_next;
    erfp_pkg::result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

/* hw/rtl/escaped_reply_frame_parser.sv */
// ----------------------------------------------------------------------------
// escaped_reply_frame_parser
// Byte-stuffed reply frame decoder with a modulo-256 sum check.
// ----------------------------------------------------------------------------
// Takes one raw byte per clock cycle when the output side keeps up; each
// accepted byte is held in the input register, and any result it forms is
// captured in the result register. The rate is set by the frame state update
// between the two registers; either stalls only when the stage after it is full.
// Payload bytes leave with tlast low; the end-of-frame status word leaves with
// tlast high. No start-up pass: bytes are taken straight after reset.
module escaped_reply_frame_parser
#(
    parameter int MAX_PAYLOAD = erfp_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [erfp_pkg::LEN_W-1:0]       cfg_wr_data,   // payload_length
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // rx_byte [7:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_data [7:0], status [10:8], device_error_code [18:11], zero [23:19]
    output logic [erfp_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic                             m_axis_tlast   // frame_done
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              can_load;
    logic              fire;
    logic              res_valid;
    erfp_pkg::result_t res;
    erfp_pkg::result_t out_res;

    assign fire = byte_valid && can_load;

    erfp_in_stage u_in
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data),
        .byte_take     (can_load)
    );

    erfp_decoder #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dec
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .rx_byte     (byte_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    erfp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, out_res.code, 3'(out_res.status), out_res.data};
    assign m_axis_tlast = out_res.done;

endmodule

/* hw/rtl/erfp_checker.sv */
// ----------------------------------------------------------------------------
// erfp_checker
// Port-level checks on the result stream of the frame parser.
// ----------------------------------------------------------------------------
module erfp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[23:8] == 16'd0)
        else $error("payload word carries status or code bits");

    a_status_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[23:19] == 5'd0 &&
            m_axis_tdata[10:8] <= 3'(erfp_pkg::ST_ESC))
        else $error("status word malformed");

    a_code_only_on_device: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast &&
            m_axis_tdata[10:8] != 3'(erfp_pkg::ST_DEVICE) |->
            m_axis_tdata[18:11] == 8'd0)
        else $error("error code without device status");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result word changed");

endmodule

bind escaped_reply_frame_parser erfp_checker u_erfp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// escaped_reply_frame_parser testbench
// Drives raw serial bytes into the parser: hand-built frames first, then
// random frames with stuffed content, real or broken sums, trailers, noise
// and corruption, across several payload lengths. A scoreboard class
// predicts every payload and status word and checks the output stream.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import erfp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    class frame_scoreboard;
        result_t         expected_words[$];
        int              errors;
        phase_t          rx_phase;
        bit              escape_open;
        logic [7:0]      byte_sum;
        int              payload_left;
        bit              device_reply;
        logic [7:0]      device_code;
        logic [LEN_W-1:0] payload_len;

        function new();
            errors = 0;
            payload_len = PAYLOAD_LEN_RESET;
            clear_frame();
        endfunction

        function void clear_frame();
            rx_phase = PH_CMD;
            escape_open = 1'b0;
            byte_sum = 8'h00;
            payload_left = 0;
            device_reply = 1'b0;
            device_code = 8'h00;
        endfunction

        function void set_length(logic [LEN_W-1:0] len);
            payload_len = len;
        endfunction

        function int pending_count();
            return expected_words.size();
        endfunction

        function void close_frame(status_t st, logic [7:0] code);
            result_t w;
            w.data = 8'h00;
            w.done = 1'b1;
            w.status = st;
            w.code = (st == ST_DEVICE) ? code : 8'h00;
            expected_words.push_back(w);
            clear_frame();
        endfunction

        function void close_checked();
            if (byte_sum != 8'h00)
                close_frame(ST_CSUM, 8'h00);
            else if (device_reply)
                close_frame(ST_DEVICE, device_code);
            else
                close_frame(ST_OK, 8'h00);
        endfunction

        function void note_byte(logic [7:0] raw);
            logic [7:0] ch;
            result_t    w;
            if (rx_phase != PH_TRAILER)
                byte_sum = byte_sum + raw;
            if (escape_open)
            begin
                escape_open = 1'b0;
                if (raw == ESC_LF)
                    ch = LF_BYTE;
                else if (raw == ESC_ESC)
                    ch = ESC_BYTE;
                else
                begin
                    close_frame(ST_ESC, 8'h00);
                    return;
                end
            end
            else if (raw == ESC_BYTE)
            begin
                escape_open = 1'b1;
                return;
            end
            else
                ch = raw;
            case (rx_phase)
                PH_ECODE:
                begin
                    device_code = ch;
                    rx_phase = PH_CSUM;
                end
                PH_PAYLOAD:
                begin
                    w.data = ch;
                    w.done = 1'b0;
                    w.status = ST_OK;
                    w.code = 8'h00;
                    expected_words.push_back(w);
                    if (payload_left > 0)
                        payload_left--;
                    if (payload_left == 0)
                        rx_phase = PH_CSUM;
                end
                PH_CSUM:
                begin
                    if (ch == LF_BYTE)
                        close_checked();
                    else
                        rx_phase = PH_TRAILER;
                end
                PH_TRAILER:
                    close_checked();
                default:
                begin
                    if (ch == CMD_ERR)
                    begin
                        device_reply = 1'b1;
                        rx_phase = PH_ECODE;
                    end
                    else if (ch == CMD_OUT)
                    begin
                        payload_left = (payload_len > MAX_PAYLOAD_DEF) ?
                                       MAX_PAYLOAD_DEF : int'(payload_len);
                        rx_phase = (payload_left == 0) ? PH_CSUM : PH_PAYLOAD;
                    end
                    else
                        close_frame(ST_CMD, 8'h00);
                end
            endcase
        endfunction

        function void check_word(logic [TDATA_W-1:0] word, logic last);
            result_t want;
            result_t got;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, got data=%h last=%b",
                         $time, word, last);
                return;
            end
            want = expected_words.pop_front();
            got.data = word[7:0];
            got.done = last;
            got.status = status_t'(word[10:8]);
            got.code = word[18:11];
            if (got.data !== want.data)
            begin
                errors++;
                $display("%0t: out_data expected %h got %h", $time, want.data, got.data);
            end
            if (got.done !== want.done)
            begin
                errors++;
                $display("%0t: frame_done expected %b got %b", $time, want.done, got.done);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            end
            if (got.code !== want.code)
            begin
                errors++;
                $display("%0t: device_error_code expected %h got %h",
                         $time, want.code, got.code);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]     cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;

    frame_scoreboard      sb = new();
    logic [7:0]           frame_q[$];
    logic [7:0]           frame_sum;
    int                   gap_pct = 20;
    bit                   rx_busy = 1'b1;
    bit                   hold_req = 1'b0;
    int                   hold_left = 0;
    int                   cycles = 0;

    escaped_reply_frame_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("escaped_reply_frame_parser test failed");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tlast);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(rx_busy && $urandom_range(0, 99) < 20);
        end
    end

    task automatic send_byte(logic [7:0] b);
        while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i]);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_length(len);
    endtask

    function automatic void put_raw(logic [7:0] b);
        frame_q.push_back(b);
        frame_sum = frame_sum + b;
    endfunction

    function automatic void put_char(logic [7:0] ch);
        if (ch == ESC_BYTE)
        begin
            put_raw(ESC_BYTE);
            put_raw(ESC_ESC);
        end
        else if (ch == LF_BYTE && $urandom_range(0, 1) == 1)
        begin
            put_raw(ESC_BYTE);
            put_raw(ESC_LF);
        end
        else
            put_raw(ch);
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0: return LF_BYTE;
            1: return ESC_BYTE;
            2: return ESC_LF;
            3: return ESC_ESC;
            4: return CMD_ERR;
            5: return CMD_OUT;
            default: return 8'($urandom);
        endcase
    endfunction

    // One reply frame, mostly well formed; the last free byte is steered
    // so that a newline checksum still gives a zero sum.
    function automatic void build_frame(logic [LEN_W-1:0] len);
        int         kind;
        int         n;
        bit         want_lf;
        logic [7:0] v;
        logic [7:0] csum;
        frame_q.delete();
        frame_sum = 8'h00;
        kind = $urandom_range(0, 99);
        want_lf = $urandom_range(0, 1);
        if (kind < 6)
        begin
            repeat ($urandom_range(1, 4)) put_raw(8'($urandom));
            return;
        end
        if (kind < 12)
        begin
            v = pick_char();
            if (v == CMD_ERR || v == CMD_OUT)
                v = 8'h00;
            put_char(v);
            return;
        end
        if (kind < 45)
        begin
            put_char(CMD_ERR);
            n = 1;
        end
        else
        begin
            put_char(CMD_OUT);
            n = (len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(len);
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1 && want_lf)
            begin
                v = 8'h00 - frame_sum - LF_BYTE;
                if (v == ESC_BYTE)
                    put_char(v);
                else
                    put_raw(v);
            end
            else
                put_char(pick_char());
        end
        csum = (want_lf && n > 0) ? LF_BYTE : 8'h00 - frame_sum;
        if ($urandom_range(0, 9) == 0)
            csum = csum + 8'(1 + $urandom_range(0, 254));
        if (csum == LF_BYTE && $urandom_range(0, 7) != 0)
            put_raw(LF_BYTE);
        else
            put_char(csum);
        if (csum != LF_BYTE)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                put_raw(ESC_BYTE);
                put_raw(8'($urandom));
            end
            else
                put_char(pick_char());
        end
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(0, frame_q.size() - 1);
            frame_q[n] = frame_q[n] ^ 8'($urandom_range(1, 255));
        end
    endfunction

    initial
    begin
        logic [LEN_W-1:0] len;
        int               phase_bytes;
        int               budget;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_length(9'd2);
        frame_q = '{8'h78,
                    ESC_BYTE, 8'h00,
                    CMD_ERR, 8'hFF, 8'h9C, LF_BYTE,
                    CMD_ERR, 8'h01, 8'h00, ESC_BYTE, ESC_ESC,
                    CMD_OUT, ESC_BYTE, ESC_LF, ESC_BYTE, ESC_ESC, 8'h22, 8'hFF,
                    CMD_ERR, 8'h00, ESC_BYTE, 8'h41};
        send_frame();
        wait_drain();
        write_length(9'd0);
        frame_q = '{CMD_OUT, 8'h91, 8'h00};
        send_frame();

        for (int p = 0; p < 7; p++)
        begin
            wait_drain();
            case (p)
                0: len = 9'd1;
                1: len = 9'd0;
                3: len = 9'd511;
                5: len = 9'd3;
                6: len = 9'd256;
                default: len = 9'($urandom_range(1, 12));
            endcase
            write_length(len);
            budget = (len > 9'd12) ? 100 : 60;
            gap_pct = (p == 2) ? 0 : 20;
            rx_busy = (p != 2);
            if (p == 4)
                hold_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < budget)
            begin
                build_frame(len);
                phase_bytes += frame_q.size();
                send_frame();
            end
        end

        wait_drain();
        if (sb.errors == 0)
            $display("escaped_reply_frame_parser test passed");
        else
            $display("escaped_reply_frame_parser test failed");
        $finish;
    end

endmodule
